[sv/iotbp_pkg.sv]
`timescale 1ns / 1ps

package iotbp_pkg;

  // result field widths
  localparam int LBN_W    = 21;
  localparam int BYTE_W   = 12;
  localparam int WORD_W   = 9;
  localparam int SHIFT_W  = 6;
  localparam int LEVEL_W  = 2;
  localparam int SLOT_W   = 3;
  localparam int INDEX_W  = 9;
  localparam int OFFSET_W = 32;

  localparam int RESULT_W = LBN_W + BYTE_W + WORD_W + SHIFT_W + LEVEL_W + SLOT_W
                            + 2 * INDEX_W + 1;
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

  // six bytes packed into a 48-bit word, byte 0 in the top byte
  localparam int BYTES_PER_WORD = 6;
  localparam logic [SHIFT_W-1:0] TOP_SHIFT = 6'd40;

  // n / 6 == (n * 43691) >> 18 for every n below 2**17
  localparam logic [15:0] WORD_RECIP       = 16'd43691;
  localparam int          WORD_RECIP_SHIFT = 18;

  localparam logic [LEVEL_W-1:0] LEVEL_DIRECT = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_SINGLE = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_DOUBLE = 2'd2;

  typedef struct packed {
    logic [LBN_W-1:0]   logical_block;
    logic [BYTE_W-1:0]  byte_in_block;
    logic [WORD_W-1:0]  word_in_block;
    logic [SHIFT_W-1:0] byte_shift;
    logic [LEVEL_W-1:0] level;
    logic [SLOT_W-1:0]  inode_slot;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] second_index;
    logic               too_large;
  } iotbp_path_t;

endpackage

[sv/iotbp_classify.sv]
`timescale 1ns / 1ps

// Word/shift split of the in-block byte and indirection walk of the block number.
module iotbp_classify #(
  parameter int QW              = 21,
  parameter int RBW             = 12,
  parameter int ADDR_SLOTS      = 8,
  parameter int INDIRECT_LEVELS = 2,
  parameter int INDEX_BITS      = 9
) (
  input  logic [QW-1:0]            lbn,
  input  logic [RBW-1:0]           rem,
  output iotbp_pkg::iotbp_path_t   path
);

  localparam int DIRECT  = ADDR_SLOTS - INDIRECT_LEVELS;
  localparam int EW      = (QW > 2 * INDEX_BITS) ? QW + 1 : 2 * INDEX_BITS + 1;
  localparam int WPW     = RBW + 16;
  localparam int WORD_RS = iotbp_pkg::WORD_RECIP_SHIFT;

  logic [WPW-1:0]            wprod;
  logic [WPW-WORD_RS-1:0]    word;
  logic [2:0]                pos;
  logic [EW-1:0]             lbn_e;
  logic [EW-1:0]             rest;
  logic [EW-1:0]             rest2;
  logic                      is_direct;
  logic                      single_hit;
  logic                      double_hit;

  assign wprod = WPW'(rem) * WPW'(iotbp_pkg::WORD_RECIP);
  assign word  = wprod[WPW-1:WORD_RS];
  // byte position in the word; word*6 as shift-and-add
  assign pos   = 3'(rem - RBW'({word, 2'b00}) - RBW'({word, 1'b0}));

  assign lbn_e      = EW'(lbn);
  assign is_direct  = lbn_e < EW'(DIRECT);
  assign rest       = lbn_e - EW'(DIRECT);
  assign single_hit = (rest >> INDEX_BITS) == '0;
  assign rest2      = rest - (EW'(1) << INDEX_BITS);
  assign double_hit = (INDIRECT_LEVELS >= 2) && ((rest2 >> (2 * INDEX_BITS)) == '0);

  always_comb begin
    path               = '0;
    path.logical_block = iotbp_pkg::LBN_W'(lbn);
    path.byte_in_block = iotbp_pkg::BYTE_W'(rem);
    path.word_in_block = iotbp_pkg::WORD_W'(word);
    path.byte_shift    = iotbp_pkg::TOP_SHIFT - iotbp_pkg::SHIFT_W'({pos, 3'b000});
    if (is_direct) begin
      path.level      = iotbp_pkg::LEVEL_DIRECT;
      path.inode_slot = iotbp_pkg::SLOT_W'(lbn);
    end else if (single_hit) begin
      path.level       = iotbp_pkg::LEVEL_SINGLE;
      path.inode_slot  = iotbp_pkg::SLOT_W'(ADDR_SLOTS - INDIRECT_LEVELS);
      path.first_index = iotbp_pkg::INDEX_W'(rest[INDEX_BITS-1:0]);
    end else if (double_hit) begin
      path.level        = iotbp_pkg::LEVEL_DOUBLE;
      path.inode_slot   = iotbp_pkg::SLOT_W'(ADDR_SLOTS - 1);
      path.first_index  = iotbp_pkg::INDEX_W'(rest2[2*INDEX_BITS-1:INDEX_BITS]);
      path.second_index = iotbp_pkg::INDEX_W'(rest2[INDEX_BITS-1:0]);
    end else begin
      path.too_large = 1'b1;
    end
  end

endmodule

[sv/inode_offset_to_block_path_core.sv]
`timescale 1ns / 1ps

// Channel   Dir  Beat         Contents
// s_axis    in   32-bit word  byte_offset
// m_axis    out  72-bit word  logical_block .. too_large, one result per offset
//
// Four register stages: input, 32x32 reciprocal product, remainder correction,
// result. One offset is taken every cycle while the result is not stalled.
// A stalled result holds in place while earlier stages keep filling their
// empty slots, so input stalls only once all four stages are full.
// Reset clears the stage valid bits only.
module inode_offset_to_block_path_core #(
  parameter int ADDR_SLOTS      = 8,
  parameter int INDIRECT_LEVELS = 2,
  parameter int INDEX_BITS      = 9,
  parameter int BLOCK_BYTES     = 3072
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [iotbp_pkg::OFFSET_W-1:0]     s_tdata,  // [31:0] byte_offset
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [20:0] logical_block, [32:21] byte_in_block, [41:33] word_in_block,
  // [47:42] byte_shift, [49:48] level, [52:50] inode_slot,
  // [61:53] first_index, [70:62] second_index, [71] too_large
  output logic [iotbp_pkg::TDATA_W-1:0]      m_tdata
);

  localparam int FL  = $clog2(BLOCK_BYTES + 1) - 1;  // floor(log2)
  localparam int SH  = 32 + FL;
  localparam int QW  = 32 - FL;
  localparam int RW  = $clog2(2 * BLOCK_BYTES);
  localparam int RBW = $clog2(BLOCK_BYTES);
  localparam logic [63:0] MULT = ((64'd1 << SH) - 64'd1) / BLOCK_BYTES;

  // stage 0: input
  logic                    v0;
  logic [31:0]             off0;
  // stage 1: approximate quotient, low in-block bits of the offset
  logic                    v1;
  logic [QW-1:0]           q1;
  logic [RW-1:0]           lo1;
  // stage 2: exact quotient and remainder
  logic                    v2;
  logic [QW-1:0]           q2;
  logic [RBW-1:0]          r2;
  // stage 3: result
  logic                    v3;
  iotbp_pkg::iotbp_path_t  res;

  logic                    rdy0, rdy1, rdy2, rdy3;
  logic [63:0]             prod;
  logic [RW-1:0]           qb;
  logic [RW-1:0]           r_raw;
  logic                    corr;
  iotbp_pkg::iotbp_path_t  path;

  assign rdy3 = !v3 || m_tready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign s_tready = rdy0;

  // quotient estimate is low by at most one
  assign prod  = 64'(off0) * 64'(MULT[31:0]);
  assign qb    = RW'(q1[RW-1:0] * RW'(BLOCK_BYTES));
  assign r_raw = lo1 - qb;
  assign corr  = r_raw >= RW'(BLOCK_BYTES);

  iotbp_classify #(
    .QW              (QW),
    .RBW             (RBW),
    .ADDR_SLOTS      (ADDR_SLOTS),
    .INDIRECT_LEVELS (INDIRECT_LEVELS),
    .INDEX_BITS      (INDEX_BITS)
  ) u_classify (
    .lbn  (q2),
    .rem  (r2),
    .path (path)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy0) v0 <= s_tvalid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && s_tvalid) begin
      off0 <= s_tdata;
    end
    if (rdy1 && v0) begin
      q1  <= prod[63:SH];
      lo1 <= off0[RW-1:0];
    end
    if (rdy2 && v1) begin
      q2 <= q1 + QW'(corr);
      r2 <= corr ? RBW'(r_raw - RW'(BLOCK_BYTES)) : RBW'(r_raw);
    end
    if (rdy3 && v2) begin
      res <= path;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = iotbp_pkg::TDATA_W'({res.too_large, res.second_index, res.first_index,
                                         res.inode_slot, res.level, res.byte_shift,
                                         res.word_in_block, res.byte_in_block,
                                         res.logical_block});

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (RW'(r2) < RW'(BLOCK_BYTES)))
    else $error("remainder not below block size");

  a_big_clears_path: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.too_large) |->
      (res.level == iotbp_pkg::LEVEL_DIRECT && res.inode_slot == '0 &&
       res.first_index == '0 && res.second_index == '0))
    else $error("too_large result carries path fields");

  a_direct_no_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.level == iotbp_pkg::LEVEL_DIRECT) |->
      (res.first_index == '0 && res.second_index == '0))
    else $error("direct block carries indirect indices");

  a_shift_on_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.byte_shift[2:0] == 3'd0 && res.byte_shift <= iotbp_pkg::TOP_SHIFT))
    else $error("byte shift off a byte boundary");

  a_single_only_when_not_double: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.level == iotbp_pkg::LEVEL_SINGLE) |-> (res.second_index == '0))
    else $error("single indirect carries second index");

endmodule
